// ===== rtl/arh_pkg.sv =====
// Shared constants, codes and types of the auto-ranging histogram.
package arh_pkg;

   // Fixed field widths of the channels.
   localparam int CMD_W      = 2;
   localparam int SAMPLE_W   = 32;
   localparam int RIDX_W     = 10;
   localparam int STATUS_W   = 2;
   localparam int OUT_CNT_W  = 32;
   localparam int POS_W      = 10;
   localparam int START_W    = 48;
   localparam int USED_OUT_W = 11;
   localparam int WIDTH_W    = 31;

   // Datapath widths: signed difference, rounded-division numerator, multiplier operand.
   localparam int DIFF_W   = 49;
   localparam int QUO_W    = DIFF_W + 2;
   localparam int MUL_OP_W = 32;
   localparam int PROD_W   = WIDTH_W + MUL_OP_W;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_BIN_WIDTH = '0;

   localparam logic [WIDTH_W-1:0] BIN_WIDTH_RESET = WIDTH_W'(65536);

   // Parameter defaults.
   localparam int NUM_BINS_DEFAULT    = 1024;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_DROPPED   = 2'd1,
      STATUS_BAD_INDEX = 2'd2
   } status_type;

endpackage

// ===== rtl/arh_ifs.sv =====
// Request and response channel interfaces of the auto-ranging histogram.
interface arh_req_if;
   logic                              valid;
   logic                              ready;
   logic [arh_pkg::CMD_W-1:0]         command;
   logic signed [arh_pkg::SAMPLE_W-1:0] sample_value;
   logic [arh_pkg::RIDX_W-1:0]        read_index;

   modport source (output valid, command, sample_value, read_index, input ready);
   modport sink   (input valid, command, sample_value, read_index, output ready);
endinterface

interface arh_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [arh_pkg::STATUS_W-1:0]        status;
   logic [arh_pkg::OUT_CNT_W-1:0]       bin_count;
   logic [arh_pkg::POS_W-1:0]           bin_position;
   logic signed [arh_pkg::START_W-1:0]  range_start;
   logic [arh_pkg::USED_OUT_W-1:0]      bins_used;

   modport source (output valid, status, bin_count, bin_position, range_start, bins_used,
                   input ready);
   modport sink   (input valid, status, bin_count, bin_position, range_start, bins_used,
                   output ready);
endinterface

// ===== rtl/auto_ranging_histogram_unit.sv =====
// Auto-ranging histogram: sequencer, divider and shared multiplier, bin memory.
//
// One item at a time. For an add-sample item the rounded bin index comes from a restoring
// divider that retires one quotient bit per cycle over a 51-bit numerator; a first sample
// or a prepend then takes one multiply for the start edge, and a kept sample ends with a
// read-modify-write of the bin memory, which has one write port and one registered read
// port. A clear item and reset both run a clearing pass that writes one memory entry per
// cycle, NUM_BINS entries in all; req ready stays low during it, configuration writes are
// still taken. Bins outside the range in use are always zero, so bins that the range
// grows over need no clearing. The response sits in an output register, so the next
// item is taken while a response still waits. bin_width is written through the APB-style
// port at byte address 0; writes at other addresses are ignored and read back zero.
module auto_ranging_histogram_unit #(
   parameter int NUM_BINS    = arh_pkg::NUM_BINS_DEFAULT,
   parameter int COUNT_WIDTH = arh_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   arh_req_if.sink                          req_chan,
   arh_rsp_if.source                        rsp_chan,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [arh_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [arh_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [arh_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   localparam int IDX_W   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int USED_W  = $clog2(NUM_BINS + 1);
   localparam int STEP_W  = $clog2(arh_pkg::QUO_W);
   localparam int DIFF_W  = arh_pkg::DIFF_W;
   localparam int QUO_W   = arh_pkg::QUO_W;
   localparam int START_W = arh_pkg::START_W;
   localparam int WIDTH_W = arh_pkg::WIDTH_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_CHECK,
      S_DIFF,
      S_ABS,
      S_PREP,
      S_DIV,
      S_DECIDE,
      S_MUL,
      S_START,
      S_SLOT,
      S_MEM_RD,
      S_MEM_WR,
      S_FINISH
   } state_type;

   // Control state
   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          sweep_ff, sweep_in;
   logic                      reply_ff, reply_in;
   logic [IDX_W-1:0]          base_ff, base_in;
   logic [USED_W-1:0]         used_ff, used_in;
   logic signed [START_W-1:0] start_ff, start_in;
   logic [WIDTH_W-1:0]        width_ff, width_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Item and datapath registers
   logic [arh_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [arh_pkg::SAMPLE_W-1:0] x_ff, x_in;
   logic [arh_pkg::RIDX_W-1:0]   ridx_ff, ridx_in;
   logic                         first_ff, first_in;
   logic [DIFF_W-1:0]            diff_ff, diff_in;
   logic                         dneg_ff, dneg_in;
   logic [DIFF_W-1:0]            mag_ff, mag_in;
   logic [QUO_W-1:0]             quo_ff, quo_in;
   logic [WIDTH_W:0]             rem_ff, rem_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic                         neg_ff, neg_in;
   logic [arh_pkg::MUL_OP_W-1:0] mul_op_ff, mul_op_in;
   logic [START_W-1:0]           prod_ff, prod_in;
   logic [IDX_W-1:0]             pos_ff, pos_in;
   logic [IDX_W-1:0]             addr_ff, addr_in;
   arh_pkg::status_type          res_status_ff, res_status_in;
   logic [COUNT_WIDTH-1:0]       res_count_ff, res_count_in;
   logic [IDX_W-1:0]             res_pos_ff, res_pos_in;

   // Response register
   logic [arh_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [arh_pkg::OUT_CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [arh_pkg::POS_W-1:0]          rsp_pos_ff, rsp_pos_in;
   logic signed [START_W-1:0]          rsp_start_ff, rsp_start_in;
   logic [arh_pkg::USED_OUT_W-1:0]     rsp_used_ff, rsp_used_in;

   // Bin memory
   logic [COUNT_WIDTH-1:0] bin_store_ff [NUM_BINS];
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [COUNT_WIDTH-1:0] mem_wdata;

   // Combinational helpers
   logic                         req_fire;
   logic                         csr_write;
   logic                         csr_hit;
   logic [arh_pkg::PROD_W-1:0]   mul_full;
   logic [WIDTH_W+1:0]           rem_shift;
   logic [WIDTH_W+1:0]           divisor;
   logic                         rem_ge;
   logic                         q_neg;
   logic [IDX_W-1:0]             q_idx;
   logic [IDX_W:0]               slot_sum;
   logic [COUNT_WIDTH-1:0]       count_inc;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire       = req_chan.valid & req_chan.ready;

   assign csr_hit   = (paddr[arh_pkg::CSR_ADDR_W-1:2] == arh_pkg::CSR_BIN_WIDTH);
   assign csr_write = psel & penable & pwrite & pready;
   assign pready    = 1'b1;
   assign prdata    = csr_hit ? arh_pkg::CSR_DATA_W'(width_ff) : '0;

   // Shared multiplier: start edge of a first sample, or shift of a prepend
   assign mul_full = arh_pkg::PROD_W'(width_ff) * arh_pkg::PROD_W'(mul_op_ff);

   // Restoring divider step against twice the bin width
   assign divisor   = {1'b0, width_ff, 1'b0};
   assign rem_shift = {rem_ff, quo_ff[QUO_W-1]};
   assign rem_ge    = (rem_shift >= divisor);

   assign q_neg     = dneg_ff & (quo_ff != '0);
   assign q_idx     = IDX_W'(quo_ff);
   assign slot_sum  = {1'b0, base_ff} + {1'b0, pos_ff};
   assign count_inc = (rd_data_ff == COUNT_MAX) ? rd_data_ff : rd_data_ff + 1'b1;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.bin_count    = rsp_count_ff;
   assign rsp_chan.bin_position = rsp_pos_ff;
   assign rsp_chan.range_start  = rsp_start_ff;
   assign rsp_chan.bins_used    = rsp_used_ff;

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      reply_in      = reply_ff;
      base_in       = base_ff;
      used_in       = used_ff;
      start_in      = start_ff;
      width_in      = width_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_chan.ready;
      cmd_in        = cmd_ff;
      x_in          = x_ff;
      ridx_in       = ridx_ff;
      first_in      = first_ff;
      diff_in       = diff_ff;
      dneg_in       = dneg_ff;
      mag_in        = mag_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      neg_in        = neg_ff;
      mul_op_in     = mul_op_ff;
      prod_in       = prod_ff;
      pos_in        = pos_ff;
      addr_in       = addr_ff;
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      res_pos_in    = res_pos_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_used_in   = rsp_used_ff;
      mem_we        = 1'b0;
      mem_waddr     = sweep_ff;
      mem_wdata     = '0;

      if (csr_write && csr_hit) begin
         width_in = WIDTH_W'(pwdata);
      end

      unique case (state_ff)
         S_SWEEP: begin
            mem_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == IDX_W'(NUM_BINS - 1)) begin
               sweep_in = '0;
               state_in = reply_ff ? S_FINISH : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               cmd_in        = req_chan.command;
               x_in          = req_chan.sample_value;
               ridx_in       = req_chan.read_index;
               res_status_in = arh_pkg::STATUS_OK;
               res_count_in  = '0;
               res_pos_in    = '0;
               priority case (req_chan.command)
                  arh_pkg::CMD_ADD:  state_in = S_DIFF;
                  arh_pkg::CMD_READ: state_in = S_CHECK;
                  arh_pkg::CMD_CLEAR: begin
                     // empty the range now, then sweep the store
                     base_in  = '0;
                     used_in  = '0;
                     start_in = '0;
                     sweep_in = '0;
                     reply_in = 1'b1;
                     state_in = S_SWEEP;
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_CHECK: begin
            if (32'(ridx_ff) >= 32'(used_ff)) begin
               res_status_in = arh_pkg::STATUS_BAD_INDEX;
               state_in      = S_FINISH;
            end else begin
               pos_in   = IDX_W'(ridx_ff);
               state_in = S_SLOT;
            end
         end
         S_DIFF: begin
            first_in = (used_ff == '0);
            if (used_ff == '0) begin
               diff_in = {{(DIFF_W-arh_pkg::SAMPLE_W){x_ff[arh_pkg::SAMPLE_W-1]}}, x_ff};
            end else begin
               diff_in = {{(DIFF_W-arh_pkg::SAMPLE_W){x_ff[arh_pkg::SAMPLE_W-1]}}, x_ff}
                       - {start_ff[START_W-1], start_ff};
            end
            state_in = S_ABS;
         end
         S_ABS: begin
            dneg_in  = diff_ff[DIFF_W-1];
            mag_in   = diff_ff[DIFF_W-1] ? (DIFF_W'(0) - diff_ff) : diff_ff;
            state_in = S_PREP;
         end
         S_PREP: begin
            rem_in = '0;
            if (width_ff == '0) begin
               // zero width puts every sample in bin zero
               quo_in   = '0;
               state_in = S_DECIDE;
            end else begin
               quo_in   = QUO_W'({mag_ff, 1'b0}) + QUO_W'(width_ff);
               step_in  = STEP_W'(QUO_W - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = rem_ge ? (WIDTH_W+1)'(rem_shift - divisor) : (WIDTH_W+1)'(rem_shift);
            quo_in  = {quo_ff[QUO_W-2:0], rem_ge};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            neg_in    = q_neg;
            mul_op_in = arh_pkg::MUL_OP_W'(quo_ff);
            priority if (first_ff) begin
               used_in  = USED_W'(1);
               pos_in   = '0;
               state_in = S_MUL;
            end else if (q_neg) begin
               if (quo_ff > (QUO_W'(NUM_BINS) - QUO_W'(used_ff))) begin
                  res_status_in = arh_pkg::STATUS_DROPPED;
                  state_in      = S_FINISH;
               end else begin
                  // prepend: move the lowest slot down, circularly
                  base_in  = (base_ff >= q_idx) ? base_ff - q_idx
                                                : base_ff - q_idx + IDX_W'(NUM_BINS);
                  used_in  = used_ff + USED_W'(quo_ff);
                  pos_in   = '0;
                  state_in = S_MUL;
               end
            end else if (quo_ff >= QUO_W'(used_ff)) begin
               if (quo_ff >= QUO_W'(NUM_BINS)) begin
                  res_status_in = arh_pkg::STATUS_DROPPED;
                  state_in      = S_FINISH;
               end else begin
                  // append: the new bins are already zero
                  pos_in   = q_idx;
                  used_in  = USED_W'(quo_ff) + 1'b1;
                  state_in = S_SLOT;
               end
            end else begin
               pos_in   = q_idx;
               state_in = S_SLOT;
            end
         end
         S_MUL: begin
            prod_in  = START_W'(mul_full);
            state_in = S_START;
         end
         S_START: begin
            if (first_ff) begin
               start_in = neg_ff ? -$signed(prod_ff) : $signed(prod_ff);
            end else begin
               start_in = start_ff - $signed(prod_ff);
            end
            state_in = S_SLOT;
         end
         S_SLOT: begin
            addr_in  = (slot_sum >= (IDX_W+1)'(NUM_BINS)) ? IDX_W'(slot_sum - (IDX_W+1)'(NUM_BINS))
                                                          : IDX_W'(slot_sum);
            state_in = S_MEM_RD;
         end
         S_MEM_RD: begin
            state_in = S_MEM_WR;
         end
         S_MEM_WR: begin
            res_pos_in = pos_ff;
            if (cmd_ff == arh_pkg::CMD_ADD) begin
               mem_we       = 1'b1;
               mem_waddr    = addr_ff;
               mem_wdata    = count_inc;
               res_count_in = count_inc;
            end else begin
               res_count_in = rd_data_ff;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_count_in  = arh_pkg::OUT_CNT_W'(res_count_ff);
               rsp_pos_in    = arh_pkg::POS_W'(res_pos_ff);
               rsp_start_in  = start_ff;
               rsp_used_in   = arh_pkg::USED_OUT_W'(used_ff);
               reply_in      = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         reply_ff     <= 1'b0;
         base_ff      <= '0;
         used_ff      <= '0;
         start_ff     <= '0;
         width_ff     <= arh_pkg::BIN_WIDTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         reply_ff      <= reply_in;
         base_ff       <= base_in;
         used_ff       <= used_in;
         start_ff      <= start_in;
         width_ff      <= width_in;
         rsp_valid_ff  <= rsp_valid_in;
         cmd_ff        <= cmd_in;
         x_ff          <= x_in;
         ridx_ff       <= ridx_in;
         first_ff      <= first_in;
         diff_ff       <= diff_in;
         dneg_ff       <= dneg_in;
         mag_ff        <= mag_in;
         quo_ff        <= quo_in;
         rem_ff        <= rem_in;
         step_ff       <= step_in;
         neg_ff        <= neg_in;
         mul_op_ff     <= mul_op_in;
         prod_ff       <= prod_in;
         pos_ff        <= pos_in;
         addr_ff       <= addr_in;
         res_status_ff <= res_status_in;
         res_count_ff  <= res_count_in;
         res_pos_ff    <= res_pos_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_start_ff  <= rsp_start_in;
         rsp_used_ff   <= rsp_used_in;
      end
   end

   // Bin memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_store_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= bin_store_ff[addr_ff];
   end

endmodule

// ===== rtl/arh_checker.sv =====
// Port-level checker of the auto-ranging histogram, bound to the top level.
module arh_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [arh_pkg::STATUS_W-1:0]        rsp_status,
   input logic [arh_pkg::OUT_CNT_W-1:0]       rsp_bin_count,
   input logic [arh_pkg::POS_W-1:0]           rsp_bin_position,
   input logic [arh_pkg::START_W-1:0]         rsp_range_start,
   input logic [arh_pkg::USED_OUT_W-1:0]      rsp_bins_used
);

   // the clearing pass keeps the block busy after reset
   a_reset_busy: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken straight after reset");

   // one item at a time
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready held after an accepted item");

   // errors report no bin
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != arh_pkg::STATUS_OK |->
         rsp_bin_count == '0 && rsp_bin_position == '0)
      else $error("error response carries a bin");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_bin_count)
         && $stable(rsp_bin_position) && $stable(rsp_range_start) && $stable(rsp_bins_used))
      else $error("stalled response changed");

endmodule

bind auto_ranging_histogram_unit arh_checker u_arh_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_bin_count    (rsp_chan.bin_count),
   .rsp_bin_position (rsp_chan.bin_position),
   .rsp_range_start  (rsp_chan.range_start),
   .rsp_bins_used    (rsp_chan.bins_used)
);
